// ----- hdl/tcot_pkg.sv -----
// Shared types and constants for the two-channel timer.
package tcot_pkg;

  localparam int FUNC_W = 2;
  localparam int ADDR_W = 11;
  localparam int DATA_W = 32;
  localparam int CTL_W  = 8;

  // Transaction kinds
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

  // Register offsets within one channel window
  localparam logic [ADDR_W-1:0] OFS_CMP = 11'h000;
  localparam logic [ADDR_W-1:0] OFS_CNT = 11'h004;
  localparam logic [ADDR_W-1:0] OFS_TE  = 11'h010;
  localparam logic [ADDR_W-1:0] OFS_TS  = 11'h014;
  localparam logic [ADDR_W-1:0] OFS_TT  = 11'h018;
  localparam logic [ADDR_W-1:0] OFS_CTL = 11'h020;

  // Control bit 1: 1 free-running, 0 interval
  localparam int MODE_BIT = 1;

  typedef logic [2:0] reg_sel_t;
  localparam reg_sel_t SEL_NONE = 3'd0;
  localparam reg_sel_t SEL_CMP  = 3'd1;
  localparam reg_sel_t SEL_CNT  = 3'd2;
  localparam reg_sel_t SEL_TE   = 3'd3;
  localparam reg_sel_t SEL_TS   = 3'd4;
  localparam reg_sel_t SEL_TT   = 3'd5;
  localparam reg_sel_t SEL_CTL  = 3'd6;

  // Decoded bus address
  typedef struct packed {
    logic     hit;   // mapped register of an existing channel
    logic     chan;
    reg_sel_t sel;
  } dec_t;

endpackage

// ----- hdl/two_channel_os_timer_top.sv -----
// Top level of the two-channel interval / free-running timer.
//
// Usage:
//   The input channel (in_valid/in_ready, func/address/write_data) carries
//   one transaction per item: a bus read, a bus write, or one timer tick.
//   The output channel (out_valid/out_ready, read_data) returns exactly one
//   transaction per bus read; writes and ticks return nothing.
//   Address bit selection: channel = bit 0 of address / CHANNEL_STRIDE,
//   register = address mod CHANNEL_STRIDE.
// Pipeline:
//   One transaction per clock unless a read stalls behind a held result.
//   A read result passes through the input register, then the result
//   register. Throughput is one transaction per cycle under the same stall,
//   set by the single execute stage that updates the channel registers.
// Reset:
//   rst (synchronous, active high) stops both channels, clears count,
//   compare and control, and empties the pipeline.
// Stalls:
//   While out_ready is low a pending result is held. Writes and ticks keep
//   flowing; a read waiting behind a held result stalls in_ready until the
//   result register frees up.
module two_channel_os_timer_top #(
  parameter int NUM_CHANNELS   = 2,
  parameter int CHANNEL_STRIDE = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tcot_pkg::FUNC_W-1:0] func,
  input  logic [tcot_pkg::ADDR_W-1:0] address,
  input  logic [tcot_pkg::DATA_W-1:0] write_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcot_pkg::DATA_W-1:0] read_data
);
  import tcot_pkg::*;

  // Decode straight off the ports, register the result with the transaction
  dec_t in_dec;

  tcot_decode #(
    .NUM_CHANNELS  (NUM_CHANNELS),
    .CHANNEL_STRIDE(CHANNEL_STRIDE)
  ) u_decode (
    .address(address),
    .dec    (in_dec)
  );

  // Input register (stage 1)
  logic              s1_valid;
  logic [FUNC_W-1:0] s1_func;
  logic [DATA_W-1:0] s1_data;
  dec_t              s1_dec;

  logic s1_is_read;
  logic s1_fire;
  logic out_room;

  assign s1_is_read = (s1_func == FUNC_READ);
  assign out_room   = !out_valid || out_ready;
  // Non-read transactions never need the result register
  assign s1_fire    = s1_valid && (!s1_is_read || out_room);
  assign in_ready   = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func <= func;
      s1_data <= write_data;
      s1_dec  <= in_dec;
    end
  end

  // Per-channel registers and execute logic
  logic [DATA_W-1:0] chan_rd [NUM_CHANNELS];

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
    logic [DATA_W-1:0] counter;
    logic [DATA_W-1:0] counter_next;
    logic              running;
    logic              running_next;
    logic [CTL_W-1:0]  control_byte;
    logic [CTL_W-1:0]  control_byte_next;
    logic [DATA_W-1:0] compare_value;
    logic [DATA_W-1:0] compare_value_next;
    logic              sel_me;

    assign sel_me = s1_dec.hit && (s1_dec.chan == 1'(i));

    always_comb begin
      counter_next       = counter;
      running_next       = running;
      control_byte_next  = control_byte;
      compare_value_next = compare_value;
      priority if (s1_func == FUNC_WRITE && sel_me) begin
        unique case (s1_dec.sel)
          SEL_CMP: compare_value_next = s1_data;
          SEL_CTL: control_byte_next  = s1_data[CTL_W-1:0];
          SEL_TS: begin
            if (s1_data[0]) begin
              running_next = 1'b1;
              counter_next = control_byte[MODE_BIT] ? '0 : compare_value;
            end
          end
          SEL_TT: begin
            if (s1_data[0]) begin
              running_next = 1'b0;
            end
          end
          default: ;
        endcase
      end else if (s1_func == FUNC_TICK && running) begin
        // Free-running counts up; interval counts down and reloads after 0
        priority if (control_byte[MODE_BIT]) begin
          counter_next = counter + DATA_W'(1);
        end else if (compare_value == '0) begin
          counter_next = '0;
        end else if (counter == '0) begin
          counter_next = compare_value;
        end else begin
          counter_next = counter - DATA_W'(1);
        end
      end else begin
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        counter       <= '0;
        running       <= 1'b0;
        control_byte  <= '0;
        compare_value <= '0;
      end else if (s1_fire) begin
        counter       <= counter_next;
        running       <= running_next;
        control_byte  <= control_byte_next;
        compare_value <= compare_value_next;
      end
    end

    always_comb begin
      chan_rd[i] = '0;
      if (sel_me) begin
        unique case (s1_dec.sel)
          SEL_CMP: chan_rd[i] = compare_value;
          SEL_CNT: chan_rd[i] = counter;
          SEL_TE:  chan_rd[i] = DATA_W'(running);
          SEL_CTL: chan_rd[i] = DATA_W'(control_byte);
          default: chan_rd[i] = '0;
        endcase
      end
    end
  end

  // Only the addressed channel drives a nonzero value
  logic [DATA_W-1:0] rd_value;

  always_comb begin
    rd_value = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      rd_value = rd_value | chan_rd[i];
    end
  end

  // Result register (stage 2)
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_room) begin
      out_valid <= s1_fire && s1_is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (out_room && s1_fire && s1_is_read) begin
      read_data <= rd_value;
    end
  end

endmodule

// ----- hdl/tcot_decode.sv -----
// Address decoder: channel window and register select.
module tcot_decode #(
  parameter int NUM_CHANNELS   = 2,
  parameter int CHANNEL_STRIDE = 1024
) (
  input  logic [tcot_pkg::ADDR_W-1:0] address,
  output tcot_pkg::dec_t              dec
);
  import tcot_pkg::*;

  localparam int SPAN       = 1 << ADDR_W;
  localparam int NUM_BLOCKS = (SPAN + CHANNEL_STRIDE - 1) / CHANNEL_STRIDE;
  localparam int EXT_W      = ADDR_W + 2;

  logic [EXT_W-1:0]  addr_ext;
  logic [ADDR_W-1:0] offset;
  logic              chan;
  reg_sel_t          sel;

  assign addr_ext = EXT_W'(address);

  // Each window is an independent range compare; exactly one matches.
  always_comb begin
    offset = '0;
    chan   = 1'b0;
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      if (addr_ext >= EXT_W'(k * CHANNEL_STRIDE) &&
          addr_ext <  EXT_W'((k + 1) * CHANNEL_STRIDE)) begin
        offset = ADDR_W'(addr_ext - EXT_W'(k * CHANNEL_STRIDE));
        chan   = k[0];
      end
    end
  end

  always_comb begin
    unique case (offset)
      OFS_CMP: sel = SEL_CMP;
      OFS_CNT: sel = SEL_CNT;
      OFS_TE:  sel = SEL_TE;
      OFS_TS:  sel = SEL_TS;
      OFS_TT:  sel = SEL_TT;
      OFS_CTL: sel = SEL_CTL;
      default: sel = SEL_NONE;
    endcase
  end

  always_comb begin
    dec.chan = chan;
    dec.sel  = sel;
    dec.hit  = (sel != SEL_NONE) && (!chan || NUM_CHANNELS > 1);
  end

endmodule

// ----- hdl/tcot_checker.sv -----
// Port-level checker for the timer top level, with its bind.
module tcot_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [tcot_pkg::FUNC_W-1:0] func,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tcot_pkg::DATA_W-1:0] read_data
);
  import tcot_pkg::*;

  // Held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data))
    else $error("result changed or dropped while stalled");

  // Empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // A new result always comes from an earlier read, via the input and result registers
  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && func == FUNC_READ, 2))
    else $error("result without a matching read");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind two_channel_os_timer_top tcot_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .func     (func),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .read_data(read_data)
);

// ----- sim/two_channel_os_timer_checker.sv -----
// Read-data checker for the two-channel timer: mirrors channel state from accepted transactions.
`timescale 1ns / 100ps
module two_channel_os_timer_checker #(
  parameter int NUM_CHANNELS   = 2,
  parameter int CHANNEL_STRIDE = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [tcot_pkg::FUNC_W-1:0] func,
  input  logic [tcot_pkg::ADDR_W-1:0] address,
  input  logic [tcot_pkg::DATA_W-1:0] write_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [tcot_pkg::DATA_W-1:0] read_data,
  output int                          mismatches,
  output int                          waiting,
  output int                          results_checked
);
  import tcot_pkg::*;

  localparam int REPORT_MAX = 10;

  // Mirrored per-channel state
  logic [DATA_W-1:0] count_q [NUM_CHANNELS];
  logic              run_q   [NUM_CHANNELS];
  logic [CTL_W-1:0]  ctl_q   [NUM_CHANNELS];
  logic [DATA_W-1:0] cmp_q   [NUM_CHANNELS];

  logic [DATA_W-1:0] expected_read_data [$];
  int err_cnt;
  int ok_cnt;

  // One timer tick applied to every running channel
  function automatic void advance_counters();
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (run_q[c]) begin
        if (ctl_q[c][MODE_BIT]) begin
          count_q[c] = count_q[c] + DATA_W'(1);
        end else if (cmp_q[c] == '0) begin
          count_q[c] = '0;
        end else if (count_q[c] == '0) begin
          count_q[c] = cmp_q[c];
        end else begin
          count_q[c] = count_q[c] - DATA_W'(1);
        end
      end
    end
  endfunction

  function automatic logic [DATA_W-1:0] register_value(int ch, logic [ADDR_W-1:0] ofs);
    if (ch >= NUM_CHANNELS) return '0;
    case (ofs)
      OFS_CMP: return cmp_q[ch];
      OFS_CNT: return count_q[ch];
      OFS_TE:  return {{(DATA_W-1){1'b0}}, run_q[ch]};
      OFS_CTL: return {{(DATA_W-CTL_W){1'b0}}, ctl_q[ch]};
      default: return '0;
    endcase
  endfunction

  function automatic void register_write(int ch, logic [ADDR_W-1:0] ofs,
                                         logic [DATA_W-1:0] d);
    if (ch >= NUM_CHANNELS) return;
    case (ofs)
      OFS_CMP: cmp_q[ch] = d;
      OFS_CTL: ctl_q[ch] = d[CTL_W-1:0];
      OFS_TS: begin
        // start or restart; load value follows the mode at this moment
        if (d[0]) begin
          run_q[ch]   = 1'b1;
          count_q[ch] = ctl_q[ch][MODE_BIT] ? '0 : cmp_q[ch];
        end
      end
      OFS_TT: begin
        if (d[0]) run_q[ch] = 1'b0;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    int unsigned       a;
    int                ch;
    logic [ADDR_W-1:0] ofs;
    logic [DATA_W-1:0] want;
    if (rst) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        count_q[c] = '0;
        run_q[c]   = 1'b0;
        ctl_q[c]   = '0;
        cmp_q[c]   = '0;
      end
      expected_read_data.delete();
      err_cnt = 0;
      ok_cnt  = 0;
    end else begin
      // results first: a read can't return on the edge it is accepted
      if (out_valid && out_ready) begin
        if (expected_read_data.size() == 0) begin
          err_cnt++;
          if (err_cnt <= REPORT_MAX)
            $display("[%0t] read_data 0x%08h with no read outstanding", $time, read_data);
        end else begin
          want = expected_read_data.pop_front();
          ok_cnt++;
          if (read_data !== want) begin
            err_cnt++;
            if (err_cnt <= REPORT_MAX)
              $display("[%0t] read_data mismatch: expected 0x%08h actual 0x%08h",
                       $time, want, read_data);
          end
        end
      end
      if (in_valid && in_ready) begin
        a   = 32'(address);
        ch  = (a / CHANNEL_STRIDE) % 2;
        ofs = ADDR_W'(a % CHANNEL_STRIDE);
        case (func)
          FUNC_READ:  expected_read_data.push_back(register_value(ch, ofs));
          FUNC_WRITE: register_write(ch, ofs, write_data);
          FUNC_TICK:  advance_counters();
          default: ;
        endcase
      end
    end
    mismatches      <= err_cnt;
    waiting         <= expected_read_data.size();
    results_checked <= ok_cnt;
  end

endmodule

// ----- sim/two_channel_os_timer_top_tb.sv -----
// Testbench top for the two-channel timer: stimulus, flow control, timeout and verdict.
`timescale 1ns / 100ps
module two_channel_os_timer_top_tb;
  import tcot_pkg::*;

  localparam int NUM_CH       = 2;
  localparam int STRIDE       = 1024;
  localparam int RANDOM_ITEMS = 1625;
  localparam int PAUSE_EVERY  = 400;   // sender drains all reads this often
  localparam int DRAIN_CYCLES = 16;
  // Worst case per item is an idle gap plus a receiver hold-off behind a
  // read; the limit is several times the worst-case total.
  localparam int CYCLE_LIMIT  = 400000;

  // func code 3 has no meaning; the block must drop it silently
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Receiver flow-control phases
  typedef enum logic [1:0] {
    SINK_ALWAYS,
    SINK_COIN,
    SINK_HOLD
  } sink_mode_e;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [FUNC_W-1:0] func       = FUNC_READ;
  logic [ADDR_W-1:0] address    = '0;
  logic [DATA_W-1:0] write_data = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [DATA_W-1:0] read_data;

  int mismatches;
  int waiting;
  int results_checked;

  int cycles     = 0;
  int burst_left = 0;
  int n_reads    = 0;
  int n_writes   = 0;
  int n_ticks    = 0;
  int n_unused   = 0;

  sink_mode_e sink_mode  = SINK_ALWAYS;
  int         sink_left  = 0;

  always #2 clk = ~clk;

  two_channel_os_timer_top #(
    .NUM_CHANNELS  (NUM_CH),
    .CHANNEL_STRIDE(STRIDE)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .address   (address),
    .write_data(write_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data)
  );

  // Mirrors the timer and checks every read result in order
  two_channel_os_timer_checker #(
    .NUM_CHANNELS  (NUM_CH),
    .CHANNEL_STRIDE(STRIDE)
  ) timer_mirror (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .address        (address),
    .write_data     (write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data),
    .mismatches     (mismatches),
    .waiting        (waiting),
    .results_checked(results_checked)
  );

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d reads still outstanding", cycles, waiting);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: phases of random length, each either always ready, ready on a
  // coin toss, or fully stalled. Independent of what the sender is doing.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_left <= 0;
    end else begin
      if (sink_left == 0) begin
        sink_mode <= sink_mode_e'($urandom_range(0, 2));
        sink_left <= int'($urandom_range(4, 30));
      end else begin
        sink_left <= sink_left - 1;
      end
      case (sink_mode)
        SINK_ALWAYS: out_ready <= 1'b1;
        SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
        default:     out_ready <= 1'b0;
      endcase
    end
  end

  function automatic logic [ADDR_W-1:0] reg_addr(int ch, logic [ADDR_W-1:0] ofs);
    return ADDR_W'(ch * STRIDE) + ofs;
  endfunction

  // Presents one transaction and returns on the edge where it is taken.
  // Bursts of back-to-back transactions are separated by random idle gaps;
  // some bursts start with no gap at all.
  task automatic send_txn(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                          input logic [DATA_W-1:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    func       <= f;
    address    <= a;
    write_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (f)
      FUNC_READ:  n_reads++;
      FUNC_WRITE: n_writes++;
      FUNC_TICK:  n_ticks++;
      default:    n_unused++;
    endcase
  endtask

  // Drop valid and hold off until every read result has come back.
  // The first edge lets the checker count the last accepted read.
  task automatic wait_for_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (waiting != 0);
  endtask

  // Random mix: mostly ticks, count reads and start triggers so channels
  // spend most of their time running; small compare values make interval
  // reloads frequent. A share of accesses hit random offsets.
  task automatic send_random_txn();
    int                roll;
    int                ch;
    logic [ADDR_W-1:0] ofs;
    logic [DATA_W-1:0] d;
    roll = $urandom_range(0, 99);
    ch   = $urandom_range(0, 1);
    d    = $urandom;
    case ($urandom_range(0, 19))
      0, 1, 2:       ofs = OFS_CMP;
      3, 4, 5, 6, 7: ofs = OFS_CNT;
      8, 9:          ofs = OFS_TE;
      10, 11, 12, 13: ofs = OFS_TS;
      14:            ofs = OFS_TT;
      15, 16:        ofs = OFS_CTL;
      default:       ofs = ADDR_W'($urandom_range(0, STRIDE - 1));
    endcase
    if (roll < 38) begin
      send_txn(FUNC_TICK, ADDR_W'($urandom), d);
    end else if (roll < 68) begin
      send_txn(FUNC_READ, reg_addr(ch, ofs), d);
    end else if (roll < 97) begin
      if (ofs == OFS_CMP && $urandom_range(0, 3) != 0) d = $urandom_range(0, 6);
      send_txn(FUNC_WRITE, reg_addr(ch, ofs), d);
    end else begin
      send_txn(FUNC_UNUSED, ADDR_W'($urandom), d);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset values, including a trigger read
    send_txn(FUNC_READ, reg_addr(0, OFS_CMP), '0);
    send_txn(FUNC_READ, reg_addr(1, OFS_CNT), '0);
    send_txn(FUNC_READ, reg_addr(0, OFS_TE), '0);
    send_txn(FUNC_READ, reg_addr(1, OFS_TS), '0);
    send_txn(FUNC_TICK, '0, '0);                      // stopped channels hold
    // Interval mode from the largest compare value
    send_txn(FUNC_WRITE, reg_addr(0, OFS_CMP), '1);
    send_txn(FUNC_WRITE, reg_addr(0, OFS_TS), 32'h1);
    send_txn(FUNC_TICK, '1, '1);
    send_txn(FUNC_READ, reg_addr(0, OFS_CNT), '0);
    // Free-running on channel 1; start with bit 0 clear does nothing
    send_txn(FUNC_WRITE, reg_addr(1, OFS_CTL), '1);
    send_txn(FUNC_WRITE, reg_addr(1, OFS_TS), 32'hFFFF_FFFE);
    send_txn(FUNC_WRITE, reg_addr(1, OFS_TS), 32'h1);
    send_txn(FUNC_TICK, '0, '0);
    send_txn(FUNC_READ, reg_addr(1, OFS_CNT), '0);
    // Compare 0 holds the count at 0, compare 1 reloads after 0,
    // then a mode change while running
    send_txn(FUNC_WRITE, reg_addr(0, OFS_CMP), '0);
    send_txn(FUNC_TICK, '0, '0);
    send_txn(FUNC_WRITE, reg_addr(0, OFS_CMP), 32'h1);
    send_txn(FUNC_TICK, '0, '0);
    send_txn(FUNC_WRITE, reg_addr(0, OFS_CTL), 32'(1 << MODE_BIT));
    send_txn(FUNC_TICK, '0, '0);
    send_txn(FUNC_READ, reg_addr(0, OFS_CNT), '0);
    // Stop twice, write to count, unused kind, unmapped and misaligned reads
    send_txn(FUNC_WRITE, reg_addr(1, OFS_TT), 32'h1);
    send_txn(FUNC_WRITE, reg_addr(1, OFS_TT), 32'h1);
    send_txn(FUNC_READ, reg_addr(1, OFS_TE), '0);
    send_txn(FUNC_WRITE, reg_addr(0, OFS_CNT), 32'h5);
    send_txn(FUNC_UNUSED, reg_addr(0, OFS_TS), 32'h1);
    send_txn(FUNC_READ, '1, '0);
    send_txn(FUNC_READ, reg_addr(0, OFS_CMP + 11'd2), '0);
    send_txn(FUNC_READ, reg_addr(1, OFS_CTL), '0);
    wait_for_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PAUSE_EVERY == PAUSE_EVERY - 1) wait_for_results();
      send_random_txn();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions: %0d reads, %0d writes, %0d ticks, %0d of unused kind",
             n_reads + n_writes + n_ticks + n_unused, n_reads, n_writes, n_ticks, n_unused);
    $display("Compared %0d read results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && waiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- two_channel_os_timer_top.f -----
hdl/tcot_pkg.sv
hdl/tcot_decode.sv
hdl/two_channel_os_timer_top.sv
hdl/tcot_checker.sv
sim/two_channel_os_timer_checker.sv
sim/two_channel_os_timer_top_tb.sv
